### rtl/bcc_fcd_pkg.sv
// Shared constants for the framed command deframer: frame geometry,
// marker bytes, parse phase codes, status and mode codes. No dependencies.
`default_nettype none

package bcc_fcd_pkg;

  // Frame length in bytes, counting header, check byte and tail (19 to 64).
  localparam int FRAME_LEN = 32;
  localparam int POS_W     = 6;

  localparam logic [POS_W-1:0] POS_LAST_PAYLOAD = POS_W'(FRAME_LEN - 3);
  localparam logic [POS_W-1:0] POS_CHECK        = POS_W'(FRAME_LEN - 2);

  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [7:0] TAIL_BYTE = 8'h0D;

  localparam logic [7:0] MODE_BYTE_AUTO   = 8'h2A;
  localparam logic [7:0] MODE_BYTE_SCOUT  = 8'h3A;
  localparam logic [7:0] MODE_BYTE_REMOTE = 8'h4A;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_AUTO   = 2'd0;
  localparam mode_t MODE_SCOUT  = 2'd1;
  localparam mode_t MODE_REMOTE = 2'd2;
  localparam mode_t MODE_NONE   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NO_TAIL  = 2'd1;
  localparam status_t ST_BAD_XOR  = 2'd2;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_HUNT    = 2'd0;
  localparam phase_t PH_COLLECT = 2'd1;
  localparam phase_t PH_DONE    = 2'd2;

  function automatic mode_t decode_mode(input logic [7:0] b);
    mode_t m;
    unique case (b)
      MODE_BYTE_AUTO:   m = MODE_AUTO;
      MODE_BYTE_SCOUT:  m = MODE_SCOUT;
      MODE_BYTE_REMOTE: m = MODE_REMOTE;
      default:          m = MODE_NONE;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/bcc_framed_command_deframer_unit.sv
// Framed command deframer, top level. Parses one command frame per burst
// from a byte stream. Depends on bcc_fcd_pkg.
//
// Usage: one received byte is taken per item, and an item can be taken in
// every clock cycle. in_burst_start marks the first byte of a receive burst;
// the block then hunts for the 0xFF header, collects a frame of FRAME_LEN
// bytes (header, payload, check byte, 0x0D tail) and produces exactly one
// result item on the tail byte. Bytes after that frame, and bursts without a
// header, produce nothing. The result carries a status (accepted, tail
// missing, check mismatch) and the held command fields; only an accepted
// frame updates them. The result appears in the output register in the cycle
// after its tail byte is taken. While a result waits, further bytes are still
// taken; only a tail byte that would produce a second result is held off
// until the waiting result is taken, so in_ready drops for that byte alone.
`default_nettype none

module bcc_framed_command_deframer_unit (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [7:0]              in_rx_byte,
  input  wire                     in_burst_start,
  output logic                    out_valid,
  input  wire                     out_ready,
  output bcc_fcd_pkg::status_t    out_frame_status,
  output logic [31:0]             out_command_id,
  output bcc_fcd_pkg::mode_t      out_command_mode,
  output logic [7:0]              out_shoot_flag,
  output logic [31:0]             out_yaw_bits,
  output logic [31:0]             out_pitch_bits,
  output logic [7:0]              out_enemy_number
);
  import bcc_fcd_pkg::*;

  // Parser state.
  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       check_r, check_nxt;

  // Fields gathered from the frame in progress.
  logic [31:0] stg_id_r, stg_id_nxt;
  mode_t       stg_mode_r, stg_mode_nxt;
  logic [7:0]  stg_shoot_r, stg_shoot_nxt;
  logic [31:0] stg_yaw_r, stg_yaw_nxt;
  logic [31:0] stg_pitch_r, stg_pitch_nxt;
  logic [7:0]  stg_enemy_r, stg_enemy_nxt;

  // Held command, driven straight onto the result fields. It can only change
  // when a result is loaded, so it stays put while a result waits.
  logic [31:0] held_id_r, held_id_nxt;
  mode_t       held_mode_r, held_mode_nxt;
  logic [7:0]  held_shoot_r, held_shoot_nxt;
  logic [31:0] held_yaw_r, held_yaw_nxt;
  logic [31:0] held_pitch_r, held_pitch_nxt;
  logic [7:0]  held_enemy_r, held_enemy_nxt;

  // Result register.
  logic    out_valid_r, out_valid_nxt;
  status_t status_r, status_nxt;

  phase_t     phase_eff;
  logic       at_tail;
  logic       accept;
  logic       out_free;
  logic [1:0] lane;

  // A burst start rearms hunting and the same byte is examined for a header.
  assign phase_eff = in_burst_start ? PH_HUNT : phase_r;
  assign at_tail   = (phase_eff == PH_COLLECT) && (pos_r > POS_CHECK);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = out_free || !at_tail;
  assign accept    = in_valid && in_ready;

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    xor_nxt        = xor_r;
    check_nxt      = check_r;
    stg_id_nxt     = stg_id_r;
    stg_mode_nxt   = stg_mode_r;
    stg_shoot_nxt  = stg_shoot_r;
    stg_yaw_nxt    = stg_yaw_r;
    stg_pitch_nxt  = stg_pitch_r;
    stg_enemy_nxt  = stg_enemy_r;
    held_id_nxt    = held_id_r;
    held_mode_nxt  = held_mode_r;
    held_shoot_nxt = held_shoot_r;
    held_yaw_nxt   = held_yaw_r;
    held_pitch_nxt = held_pitch_r;
    held_enemy_nxt = held_enemy_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    lane           = 2'd0;

    if (accept) begin
      phase_nxt = phase_eff;
      unique case (phase_eff)
        PH_HUNT: begin
          if (in_rx_byte == HDR_BYTE) begin
            phase_nxt = PH_COLLECT;
            pos_nxt   = POS_W'(1);
            xor_nxt   = 8'h00;
          end
        end
        PH_COLLECT: begin
          if (pos_r <= POS_LAST_PAYLOAD) begin
            // Payload byte: fold into the check and stage the command field.
            xor_nxt = xor_r ^ in_rx_byte;
            if (pos_r >= POS_W'(1) && pos_r <= POS_W'(4)) begin
              lane = 2'(pos_r - POS_W'(1));
              stg_id_nxt[{lane, 3'b000} +: 8] = in_rx_byte;
            end else if (pos_r == POS_W'(5)) begin
              stg_mode_nxt = decode_mode(in_rx_byte);
            end else if (pos_r == POS_W'(6)) begin
              stg_shoot_nxt = in_rx_byte;
            end else if (pos_r >= POS_W'(7) && pos_r <= POS_W'(10)) begin
              lane = 2'(pos_r - POS_W'(7));
              stg_yaw_nxt[{lane, 3'b000} +: 8] = in_rx_byte;
            end else if (pos_r >= POS_W'(11) && pos_r <= POS_W'(14)) begin
              lane = 2'(pos_r - POS_W'(11));
              stg_pitch_nxt[{lane, 3'b000} +: 8] = in_rx_byte;
            end else if (pos_r == POS_W'(16)) begin
              stg_enemy_nxt = in_rx_byte;
            end
            pos_nxt = pos_r + POS_W'(1);
          end else if (pos_r == POS_CHECK) begin
            check_nxt = in_rx_byte;
            pos_nxt   = pos_r + POS_W'(1);
          end else begin
            // Tail byte: the frame is complete and one result is produced.
            // The tail is checked before the payload check.
            if (in_rx_byte != TAIL_BYTE) begin
              status_nxt = ST_NO_TAIL;
            end else if (xor_r != check_r) begin
              status_nxt = ST_BAD_XOR;
            end else begin
              status_nxt     = ST_OK;
              held_id_nxt    = stg_id_r;
              held_mode_nxt  = stg_mode_r;
              held_shoot_nxt = stg_shoot_r;
              held_yaw_nxt   = stg_yaw_r;
              held_pitch_nxt = stg_pitch_r;
              held_enemy_nxt = stg_enemy_r;
            end
            out_valid_nxt = 1'b1;
            phase_nxt     = PH_DONE;
            pos_nxt       = '0;
          end
        end
        default: begin
          // Done: bytes are ignored until the next burst start.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DONE;
      pos_r        <= '0;
      xor_r        <= 8'h00;
      check_r      <= 8'h00;
      stg_id_r     <= '0;
      stg_mode_r   <= MODE_NONE;
      stg_shoot_r  <= '0;
      stg_yaw_r    <= '0;
      stg_pitch_r  <= '0;
      stg_enemy_r  <= '0;
      held_id_r    <= '0;
      held_mode_r  <= MODE_NONE;
      held_shoot_r <= '0;
      held_yaw_r   <= '0;
      held_pitch_r <= '0;
      held_enemy_r <= '0;
      out_valid_r  <= 1'b0;
      status_r     <= ST_OK;
    end else begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      xor_r        <= xor_nxt;
      check_r      <= check_nxt;
      stg_id_r     <= stg_id_nxt;
      stg_mode_r   <= stg_mode_nxt;
      stg_shoot_r  <= stg_shoot_nxt;
      stg_yaw_r    <= stg_yaw_nxt;
      stg_pitch_r  <= stg_pitch_nxt;
      stg_enemy_r  <= stg_enemy_nxt;
      held_id_r    <= held_id_nxt;
      held_mode_r  <= held_mode_nxt;
      held_shoot_r <= held_shoot_nxt;
      held_yaw_r   <= held_yaw_nxt;
      held_pitch_r <= held_pitch_nxt;
      held_enemy_r <= held_enemy_nxt;
      out_valid_r  <= out_valid_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = status_r;
  assign out_command_id   = held_id_r;
  assign out_command_mode = held_mode_r;
  assign out_shoot_flag   = held_shoot_r;
  assign out_yaw_bits     = held_yaw_r;
  assign out_pitch_bits   = held_pitch_r;
  assign out_enemy_number = held_enemy_r;

endmodule

`default_nettype wire

### rtl/bcc_fcd_checker.sv
// Port-level checker for the framed command deframer, with its bind.
// Depends on bcc_fcd_pkg and bcc_framed_command_deframer_unit.
`default_nettype none

module bcc_fcd_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_valid,
  input wire                       in_ready,
  input wire [7:0]                 in_rx_byte,
  input wire                       in_burst_start,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire bcc_fcd_pkg::status_t out_frame_status,
  input wire [31:0]                out_command_id,
  input wire bcc_fcd_pkg::mode_t   out_command_mode,
  input wire [7:0]                 out_shoot_flag,
  input wire [31:0]                out_yaw_bits,
  input wire [31:0]                out_pitch_bits,
  input wire [7:0]                 out_enemy_number
);
  import bcc_fcd_pkg::*;

  // Port values seen at the previous clock edge.
  logic        prev_valid_r;
  logic        prev_ready_r;
  logic [31:0] prev_id_r;
  mode_t       prev_mode_r;
  logic [7:0]  prev_shoot_r;
  logic [31:0] prev_yaw_r;
  logic [31:0] prev_pitch_r;
  logic [7:0]  prev_enemy_r;

  logic new_result;
  logic cmd_stable;

  always_ff @(posedge clk) begin
    prev_valid_r <= out_valid;
    prev_ready_r <= out_ready;
    prev_id_r    <= out_command_id;
    prev_mode_r  <= out_command_mode;
    prev_shoot_r <= out_shoot_flag;
    prev_yaw_r   <= out_yaw_bits;
    prev_pitch_r <= out_pitch_bits;
    prev_enemy_r <= out_enemy_number;
  end

  assign new_result = out_valid && (!prev_valid_r || prev_ready_r);
  assign cmd_stable = (out_command_id == prev_id_r) && (out_command_mode == prev_mode_r) &&
                      (out_shoot_flag == prev_shoot_r) && (out_yaw_bits == prev_yaw_r) &&
                      (out_pitch_bits == prev_pitch_r) && (out_enemy_number == prev_enemy_r);

  // A waiting result holds its status and command fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_status) && cmd_stable)
    else $error("result changed while stalled");

  // The held command only moves together with a freshly produced result.
  a_cmd_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_stable |-> new_result)
    else $error("command fields changed without a result");

  // A rejected frame leaves the held command untouched.
  a_bad_frame_keeps_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    new_result && out_frame_status != ST_OK |-> cmd_stable)
    else $error("rejected frame altered the command");

  // Only the three defined status codes are ever reported.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_status == ST_OK || out_frame_status == ST_NO_TAIL ||
                  out_frame_status == ST_BAD_XOR)
    else $error("undefined frame status");

endmodule

bind bcc_framed_command_deframer_unit bcc_fcd_checker u_bcc_fcd_checker (.*);

`default_nettype wire

### test/tb_top.sv
// Testbench for the framed command deframer: it sends random and directed byte bursts, predicts
// every frame result, and checks each result item field by field.
// Depends on bcc_fcd_pkg and bcc_framed_command_deframer_unit.
`timescale 1ns / 100ps

module tb_top;
  import bcc_fcd_pkg::*;

  // One input item: a received byte and the flag that opens a new burst.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       burst_start;
  } rx_item_t;

  // One frame result. The staged and held command fields use the same layout.
  // In those copies the status field is left unused.
  typedef struct packed {
    status_t     status;
    logic [31:0] id;
    mode_t       mode;
    logic [7:0]  shoot;
    logic [31:0] yaw;
    logic [31:0] pitch;
    logic [7:0]  enemy;
  } command_t;

  localparam int RANDOM_BYTES = 1600;
  localparam int HOLD_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_burst_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  status_t     out_frame_status;
  logic [31:0] out_command_id;
  mode_t       out_command_mode;
  logic [7:0]  out_shoot_flag;
  logic [31:0] out_yaw_bits;
  logic [31:0] out_pitch_bits;
  logic [7:0]  out_enemy_number;

  bcc_framed_command_deframer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_burst_start   (in_burst_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_status (out_frame_status),
    .out_command_id   (out_command_id),
    .out_command_mode (out_command_mode),
    .out_shoot_flag   (out_shoot_flag),
    .out_yaw_bits     (out_yaw_bits),
    .out_pitch_bits   (out_pitch_bits),
    .out_enemy_number (out_enemy_number)
  );

  // The clock period is 8 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bytes still to be sent, and the frame results that are still expected.
  rx_item_t rx_queue[$];
  command_t expected_cmds[$];
  int       total_items = 0;
  int       sent_count = 0;
  int       fail_count = 0;

  // Predictor state. The values below are the state after reset. The block
  // ignores every byte until the first burst start arrives.
  phase_t     parse_st = PH_DONE;
  logic [5:0] frame_pos = '0;
  logic [7:0] xor_acc = '0;
  logic [7:0] chk_byte = '0;
  command_t   staged_cmd = '{status: ST_OK, mode: MODE_NONE, default: '0};
  command_t   held_cmd = '{status: ST_OK, mode: MODE_NONE, default: '0};

  // This task advances the predictor by one accepted byte. When the byte is
  // the tail of a frame, the task queues the result item that the frame
  // must produce.
  task automatic deframe_byte(input logic [7:0] b, input logic s);
    command_t res;
    int       p;
    p = frame_pos;
    if (s)
      parse_st = PH_HUNT;
    if (parse_st == PH_HUNT) begin
      // While hunting, only the header byte matters. A burst start on a
      // header byte opens the frame at once.
      if (b == HDR_BYTE) begin
        parse_st = PH_COLLECT;
        frame_pos = 6'd1;
        xor_acc = '0;
      end
    end else if (parse_st == PH_COLLECT) begin
      if (frame_pos <= POS_LAST_PAYLOAD) begin
        // Every payload byte enters the XOR. Byte 15 and the bytes after
        // byte 16 have no other use.
        xor_acc ^= b;
        if (p >= 1 && p <= 4)
          staged_cmd.id[(p - 1) * 8 +: 8] = b;
        else if (p == 5) begin
          case (b)
            MODE_BYTE_AUTO:   staged_cmd.mode = MODE_AUTO;
            MODE_BYTE_SCOUT:  staged_cmd.mode = MODE_SCOUT;
            MODE_BYTE_REMOTE: staged_cmd.mode = MODE_REMOTE;
            default:          staged_cmd.mode = MODE_NONE;
          endcase
        end else if (p == 6)
          staged_cmd.shoot = b;
        else if (p >= 7 && p <= 10)
          staged_cmd.yaw[(p - 7) * 8 +: 8] = b;
        else if (p >= 11 && p <= 14)
          staged_cmd.pitch[(p - 11) * 8 +: 8] = b;
        else if (p == 16)
          staged_cmd.enemy = b;
        frame_pos = frame_pos + 6'd1;
      end else if (frame_pos == POS_CHECK) begin
        chk_byte = b;
        frame_pos = frame_pos + 6'd1;
      end else begin
        // This is the tail position, so the frame is complete. The tail is
        // checked before the XOR, which means a frame with both faults
        // reports a missing tail.
        res = held_cmd;
        if (b != TAIL_BYTE)
          res.status = ST_NO_TAIL;
        else if (xor_acc != chk_byte)
          res.status = ST_BAD_XOR;
        else begin
          held_cmd = staged_cmd;
          res = staged_cmd;
          res.status = ST_OK;
        end
        parse_st = PH_DONE;
        frame_pos = '0;
        expected_cmds.push_back(res);
      end
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic s);
    rx_item_t it;
    it.rx_byte = b;
    it.burst_start = s;
    rx_queue.push_back(it);
  endtask

  // This task queues one burst. The burst holds `prefix` non-header bytes,
  // then the first `keep` bytes of a frame, then `trailer` arbitrary bytes.
  // A burst with keep below FRAME_LEN has been cut short. Fill pattern: 0
  // gives random payload, 1 all zeros, 2 all ones. The mode byte always
  // replaces frame byte 5.
  task automatic queue_frame(input int prefix, input logic [7:0] mode_byte, input int fill,
                             input bit bad_check, input bit bad_tail, input int keep,
                             input int trailer);
    logic [7:0] frame [FRAME_LEN];
    logic [7:0] sum;
    logic [7:0] t;
    bit         first;
    sum = '0;
    first = 1'b1;
    frame[0] = HDR_BYTE;
    for (int p = 1; p < FRAME_LEN - 2; p++) begin
      frame[p] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
      if (p == 5)
        frame[p] = mode_byte;
      sum ^= frame[p];
    end
    frame[FRAME_LEN - 2] = bad_check ? sum ^ 8'($urandom_range(1, 255)) : sum;
    t = 8'($urandom_range(0, 254));
    if (t >= TAIL_BYTE)
      t = t + 8'd1;
    frame[FRAME_LEN - 1] = bad_tail ? t : TAIL_BYTE;
    for (int i = 0; i < prefix; i++) begin
      queue_byte(8'($urandom_range(0, 254)), first);
      first = 1'b0;
    end
    for (int i = 0; i < keep; i++) begin
      queue_byte(frame[i], first);
      first = 1'b0;
    end
    for (int i = 0; i < trailer; i++)
      queue_byte(8'($urandom), 1'b0);
  endtask

  // This task queues one burst of `len` bytes with no frame structure. When
  // allow_hdr is clear, no header byte appears, so the burst must produce
  // nothing.
  task automatic queue_noise(input int len, input bit allow_hdr);
    for (int i = 0; i < len; i++)
      queue_byte(allow_hdr ? 8'($urandom) : 8'($urandom_range(0, 254)), i == 0);
  endtask

  function automatic logic [7:0] pick_mode_byte();
    case ($urandom_range(0, 3))
      0:       return MODE_BYTE_AUTO;
      1:       return MODE_BYTE_SCOUT;
      2:       return MODE_BYTE_REMOTE;
      default: return 8'($urandom);
    endcase
  endfunction

  // The idle rate follows the progress of the stimulus. In the first third,
  // the sender idles 30% of the time and the receiver 54%. In the second
  // third, the two rates are swapped. In the last third, neither side
  // idles.
  function automatic int idle_pct(input bit sender_side);
    int ph;
    ph = (total_items == 0) ? 0 : (sent_count * 3) / total_items;
    if (ph == 0)
      return sender_side ? 30 : 54;
    if (ph == 1)
      return sender_side ? 54 : 30;
    return 0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // The driver keeps a byte on the input until it is accepted. Once a byte
  // has been accepted, the driver either offers the next byte in the queue
  // or idles.
  always @(posedge clk) begin : driver
    rx_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte, in_burst_start);
        sent_count <= sent_count + 1;
      end
      if (!(in_valid && !in_ready)) begin
        if (rx_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          nxt = rx_queue.pop_front();
          in_rx_byte <= nxt.rx_byte;
          in_burst_start <= nxt.burst_start;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The monitor checks every accepted result against the oldest expected
  // result. Once, in the phase with no idling, the receiver holds off for a
  // long stretch. The sender keeps sending during that time, so the block
  // must stall the next tail byte until the result that is waiting has
  // been taken.
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : monitor
    command_t exp_cmd;
    logic     rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          $error("result item arrived with no frame pending");
          fail_count++;
        end else begin
          exp_cmd = expected_cmds.pop_front();
          check_field("frame_status", 32'(exp_cmd.status), 32'(out_frame_status));
          check_field("command_id", exp_cmd.id, out_command_id);
          check_field("command_mode", 32'(exp_cmd.mode), 32'(out_command_mode));
          check_field("shoot_flag", 32'(exp_cmd.shoot), 32'(out_shoot_flag));
          check_field("yaw_bits", exp_cmd.yaw, out_yaw_bits);
          check_field("pitch_bits", exp_cmd.pitch, out_pitch_bits);
          check_field("enemy_number", 32'(exp_cmd.enemy), 32'(out_enemy_number));
        end
      end
      if (!hold_done && total_items != 0 && sent_count >= (total_items * 2) / 3 + 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
      out_ready <= rdy;
    end
  end

  // This block builds the stimulus, releases reset and waits for the run
  // to drain.
  initial begin : stimulus
    int kind;
    int target;

    // Right after reset, the block ignores every byte until a burst starts.
    // These bytes include a header byte.
    queue_byte(HDR_BYTE, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(TAIL_BYTE, 1'b0);
    // These good frames cover each mode and the extreme payload values. A
    // payload of all ones must not be taken for a new header.
    queue_frame(0, MODE_BYTE_AUTO, 1, 0, 0, FRAME_LEN, 0);
    queue_frame(2, MODE_BYTE_SCOUT, 2, 0, 0, FRAME_LEN, 0);
    queue_frame(0, MODE_BYTE_REMOTE, 0, 0, 0, FRAME_LEN, 0);
    queue_frame(1, 8'hFF, 2, 0, 0, FRAME_LEN, 0);
    // These frames carry a bad check byte, a missing tail, and both faults
    // at once. None of them may change the held fields.
    queue_frame(0, MODE_BYTE_AUTO, 0, 1, 0, FRAME_LEN, 0);
    queue_frame(0, MODE_BYTE_SCOUT, 0, 0, 1, FRAME_LEN, 0);
    queue_frame(0, MODE_BYTE_REMOTE, 0, 1, 1, FRAME_LEN, 0);
    // A burst without a header gives no result.
    queue_noise(5, 1'b0);
    // A burst cut short is dropped at the next burst start. Extra bytes
    // after a frame, including header bytes, are ignored.
    queue_frame(1, MODE_BYTE_AUTO, 0, 0, 0, FRAME_LEN / 2, 0);
    queue_frame(0, 8'h00, 0, 0, 0, FRAME_LEN, 0);
    queue_byte(HDR_BYTE, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(HDR_BYTE, 1'b0);

    target = rx_queue.size() + RANDOM_BYTES;
    while (rx_queue.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 60)
        queue_frame($urandom_range(0, 3), pick_mode_byte(), 0, 0, 0, FRAME_LEN,
                    $urandom_range(0, 3));
      else if (kind < 70)
        queue_frame($urandom_range(0, 3), pick_mode_byte(), 0, 1, 0, FRAME_LEN, 0);
      else if (kind < 78)
        queue_frame($urandom_range(0, 3), pick_mode_byte(), 0, 0, 1, FRAME_LEN, 0);
      else if (kind < 82)
        queue_frame(0, pick_mode_byte(), 0, 1, 1, FRAME_LEN, 0);
      else if (kind < 88)
        queue_noise($urandom_range(1, 6), 1'b0);
      else if (kind < 94)
        queue_frame($urandom_range(0, 2), pick_mode_byte(), 0, 0, 0,
                    $urandom_range(1, FRAME_LEN - 1), 0);
      else
        queue_noise($urandom_range(1, 40), 1'b1);
    end
    total_items = rx_queue.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < total_items)
      @(posedge clk);
    while (expected_cmds.size() != 0)
      @(posedge clk);
    // Keep clocking so that any stray result can still show.
    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // This is a safety limit. A correct run takes well under a tenth of it.
  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
